// ===== hw/rtl/newton_divided_difference_interp_defines.svh =====
// Assertion macros used by the checker file of the interpolator.
`ifndef NEWTON_DIVIDED_DIFFERENCE_INTERP_DEFINES_SVH
`define NEWTON_DIVIDED_DIFFERENCE_INTERP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NDD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ndd check failed");

// Consequent must hold in the cycle after the antecedent.
`define NDD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ndd check failed");

`endif

// ===== hw/rtl/ndd_pkg.sv =====
// Types, constants and arithmetic helpers of the divided-difference interpolator.
package ndd_pkg;

	localparam int MAX_NODES = 16;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int MAG_W     = DATA_W + 1;
	localparam int NUM_W     = MAG_W + FRAC_BITS;
	localparam int WIDE_W    = 2 * DATA_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int DSTEP_W   = $clog2(DIV_STEPS);

	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_ONE = DATA_W'(64'd1 << FRAC_BITS);
	localparam logic [WIDE_W-1:0]        SAT_LIM = WIDE_W'(1) << (DATA_W - 1);

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_EVAL   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OUT_ZERO = 2'd0,
		OUT_COEF = 2'd1,
		OUT_ACC  = 2'd2
	} out_sel_t;

	typedef struct packed {
		logic             load_start;
		logic             load_append;
		logic             query_load;
		logic [IDX_W-1:0] x_ra;
		logic [IDX_W-1:0] x_rb;
		logic [IDX_W-1:0] c_ra;
		logic [IDX_W-1:0] c_rb;
		logic [IDX_W-1:0] c_wa;
		logic             c_wr_div;
		logic             c_wr_zero;
		logic             set_dup;
		logic             set_ready;
		logic             div_start;
		logic             ev_init;
		logic             ev_mul_d;
		logic             ev_prod;
		logic             ev_mul_c;
		logic             ev_acc;
		logic             out_set;
		out_sel_t         out_sel;
		status_t          out_status;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             coef_ready;
		logic             dup;
		logic             den_zero;
		logic             div_done;
		logic             out_free;
	} sts_t;

	function automatic logic [DATA_W-1:0] mag_d(input logic signed [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [MAG_W-1:0] mag_w(input logic signed [MAG_W-1:0] v);
		return v[MAG_W-1] ? (~v + 1'b1) : v;
	endfunction

	// Magnitude and sign to a saturated signed word.
	function automatic logic signed [DATA_W-1:0] signed_sat(input logic [WIDE_W-1:0] m,
			input logic neg);
		logic [DATA_W-1:0] low;
		low = m[DATA_W-1:0];
		if (neg) begin
			if (m >= SAT_LIM) return VAL_MIN;
			return ~low + 1'b1;
		end
		if (m >= SAT_LIM) return VAL_MAX;
		return low;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_w(input logic signed [MAG_W-1:0] v);
		if (v[MAG_W-1] != v[MAG_W-2]) return v[MAG_W-1] ? VAL_MIN : VAL_MAX;
		return v[DATA_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/ndd_item_if.sv =====
// Input channel: one word per node load or evaluation request.
interface ndd_item_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  mode;
	logic signed [31:0] node_x;
	logic signed [31:0] node_y;
	logic signed [31:0] query_point;

	modport source (output valid, mode, node_x, node_y, query_point, input ready);
	modport sink (input valid, mode, node_x, node_y, query_point, output ready);
endinterface

// ===== hw/rtl/ndd_result_if.sv =====
// Output channel: one result word per accepted input word.
interface ndd_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic        [1:0]  status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

// ===== hw/rtl/ndd_div.sv =====
// Restoring divider, one quotient bit per cycle, for (num << FRAC_BITS) / den.
module ndd_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ndd_pkg::MAG_W-1:0]    num,
	input  logic signed [ndd_pkg::MAG_W-1:0]    den,
	output logic                                done,
	output logic signed [ndd_pkg::DATA_W-1:0]   quot
);
	logic                               busy_q, done_q, neg_q;
	logic [ndd_pkg::DSTEP_W-1:0]        cnt_q;
	logic [ndd_pkg::MAG_W-1:0]          rem_q, dm_q;
	logic [ndd_pkg::NUM_W-1:0]          nq_q;
	logic [ndd_pkg::MAG_W:0]            trial, diff;
	logic                               ge;
	logic                               last_step;

	assign trial     = {rem_q, nq_q[ndd_pkg::NUM_W-1]};
	assign diff      = trial - {1'b0, dm_q};
	assign ge        = trial >= {1'b0, dm_q};
	assign last_step = cnt_q == ndd_pkg::DSTEP_W'(ndd_pkg::DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= {ndd_pkg::mag_w(num), {ndd_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
			dm_q  <= ndd_pkg::mag_w(den);
			neg_q <= num[ndd_pkg::MAG_W-1] ^ den[ndd_pkg::MAG_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[ndd_pkg::MAG_W-1:0] : trial[ndd_pkg::MAG_W-1:0];
			nq_q  <= {nq_q[ndd_pkg::NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = ndd_pkg::signed_sat(ndd_pkg::WIDE_W'(nq_q), neg_q);
endmodule

// ===== hw/rtl/ndd_ctrl.sv =====
// Controller: decodes words, sequences the coefficient build and the evaluation.
module ndd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      mode,
	input  ndd_pkg::sts_t   sts,
	output logic            in_ready,
	output ndd_pkg::cmd_t   cmd
);
	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_BRD   = 12'b0000_0000_0010,
		S_BCHK  = 12'b0000_0000_0100,
		S_BDIV  = 12'b0000_0000_1000,
		S_ECHK  = 12'b0000_0001_0000,
		S_ERD0  = 12'b0000_0010_0000,
		S_EINIT = 12'b0000_0100_0000,
		S_ERD   = 12'b0000_1000_0000,
		S_ED    = 12'b0001_0000_0000,
		S_EP    = 12'b0010_0000_0000,
		S_EC    = 12'b0100_0000_0000,
		S_EA    = 12'b1000_0000_0000
	} state_t;

	state_t                     state_q, state_n;
	logic [ndd_pkg::IDX_W-1:0]  i_q, i_n, j_q, j_n, last;
	logic                       accept, building;
	state_t                     adv_state;
	logic [ndd_pkg::IDX_W-1:0]  adv_i, adv_j;
	logic                       adv_ready;

	assign in_ready = (state_q == S_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;
	assign last     = ndd_pkg::IDX_W'(sts.count - 1'b1);
	assign building = (state_q == S_BRD) || (state_q == S_BCHK) || (state_q == S_BDIV);

	// Next coefficient of the in-place table: walk each column from the top down.
	always_comb begin
		adv_state = S_BRD;
		adv_i     = i_q - 1'b1;
		adv_j     = j_q;
		adv_ready = 1'b0;
		if (i_q == j_q) begin
			if (j_q == last) begin
				adv_state = S_ECHK;
				adv_ready = 1'b1;
				adv_i     = i_q;
			end else begin
				adv_j = j_q + 1'b1;
				adv_i = last;
			end
		end
	end

	always_comb begin
		state_n        = state_q;
		i_n            = i_q;
		j_n            = j_q;
		cmd            = '0;
		cmd.out_sel    = ndd_pkg::OUT_ZERO;
		cmd.out_status = ndd_pkg::ST_OK;
		cmd.x_ra       = i_q;
		cmd.x_rb       = building ? i_q - j_q : i_q - 1'b1;
		cmd.c_ra       = i_q;
		cmd.c_rb       = i_q - 1'b1;
		cmd.c_wa       = i_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (ndd_pkg::mode_t'(mode))
						ndd_pkg::MODE_START: begin
							cmd.load_start = 1'b1;
							cmd.out_set    = 1'b1;
						end
						ndd_pkg::MODE_APPEND: begin
							cmd.out_set = 1'b1;
							if (sts.coef_ready ||
									sts.count >= ndd_pkg::CNT_W'(ndd_pkg::MAX_NODES)) begin
								cmd.out_status = ndd_pkg::ST_FULL;
							end else begin
								cmd.load_append = 1'b1;
							end
						end
						ndd_pkg::MODE_EVAL: begin
							cmd.query_load = 1'b1;
							if (sts.count == '0) begin
								cmd.out_set    = 1'b1;
								cmd.out_status = ndd_pkg::ST_EMPTY;
							end else if (sts.coef_ready) begin
								state_n = S_ECHK;
							end else if (last == '0) begin
								cmd.set_ready = 1'b1;
								state_n       = S_ECHK;
							end else begin
								i_n     = last;
								j_n     = ndd_pkg::IDX_W'(1);
								state_n = S_BRD;
							end
						end
						ndd_pkg::MODE_NONE: begin
							cmd.out_set = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_BRD: state_n = S_BCHK;
			S_BCHK: begin
				if (sts.den_zero) begin
					cmd.c_wr_zero = 1'b1;
					cmd.set_dup   = 1'b1;
					cmd.set_ready = adv_ready;
					state_n       = adv_state;
					i_n           = adv_i;
					j_n           = adv_j;
				end else begin
					cmd.div_start = 1'b1;
					state_n       = S_BDIV;
				end
			end
			S_BDIV: begin
				if (sts.div_done) begin
					cmd.c_wr_div  = 1'b1;
					cmd.set_ready = adv_ready;
					state_n       = adv_state;
					i_n           = adv_i;
					j_n           = adv_j;
				end
			end
			S_ECHK: begin
				if (sts.dup) begin
					cmd.out_set    = 1'b1;
					cmd.out_status = ndd_pkg::ST_DUP;
					state_n        = S_IDLE;
				end else begin
					i_n     = '0;
					state_n = S_ERD0;
				end
			end
			S_ERD0: state_n = S_EINIT;
			S_EINIT: begin
				cmd.ev_init = 1'b1;
				if (last == '0) begin
					cmd.out_set = 1'b1;
					cmd.out_sel = ndd_pkg::OUT_COEF;
					state_n     = S_IDLE;
				end else begin
					i_n     = ndd_pkg::IDX_W'(1);
					state_n = S_ERD;
				end
			end
			S_ERD: state_n = S_ED;
			S_ED: begin
				cmd.ev_mul_d = 1'b1;
				state_n      = S_EP;
			end
			S_EP: begin
				cmd.ev_prod = 1'b1;
				state_n     = S_EC;
			end
			S_EC: begin
				cmd.ev_mul_c = 1'b1;
				state_n      = S_EA;
			end
			S_EA: begin
				cmd.ev_acc = 1'b1;
				if (i_q == last) begin
					cmd.out_set = 1'b1;
					cmd.out_sel = ndd_pkg::OUT_ACC;
					state_n     = S_IDLE;
				end else begin
					i_n     = i_q + 1'b1;
					state_n = S_ERD;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_n;
			i_q     <= i_n;
			j_q     <= j_n;
		end
	end
endmodule

// ===== hw/rtl/ndd_dp.sv =====
// Datapath: node stores, difference and divide unit, multiply-add, result register.
module ndd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ndd_pkg::cmd_t                       cmd,
	input  logic signed [ndd_pkg::DATA_W-1:0]   node_x,
	input  logic signed [ndd_pkg::DATA_W-1:0]   node_y,
	input  logic signed [ndd_pkg::DATA_W-1:0]   query_point,
	input  logic                                res_ready,
	output ndd_pkg::sts_t                       sts,
	output logic                                res_valid,
	output logic signed [ndd_pkg::DATA_W-1:0]   res_value,
	output logic [1:0]                          res_status
);
	localparam int DW = ndd_pkg::DATA_W;

	logic signed [DW-1:0]           x_mem [ndd_pkg::MAX_NODES];
	logic signed [DW-1:0]           c_mem [ndd_pkg::MAX_NODES];
	logic signed [DW-1:0]           x_a_q, x_b_q, c_a_q, c_b_q;
	logic [ndd_pkg::CNT_W-1:0]      count_q;
	logic                           ready_q, dup_q;
	logic [ndd_pkg::IDX_W-1:0]      load_idx;

	logic                           c_we;
	logic [ndd_pkg::IDX_W-1:0]      c_wa;
	logic signed [DW-1:0]           c_wd;

	logic signed [DW:0]             den, num;
	logic                           div_done;
	logic signed [DW-1:0]           quot;

	logic signed [DW-1:0]           q_q, prod_q, acc_q, d, p_sat, acc_next;
	logic [ndd_pkg::WIDE_W-1:0]     p_q;
	logic                           p_neg_q;
	logic [DW-1:0]                  mul_a, mul_b;
	logic                           mul_neg;

	logic                           res_valid_q;
	logic signed [DW-1:0]           res_value_q;
	logic [1:0]                     res_status_q;

	assign load_idx = cmd.load_start ? '0 : count_q[ndd_pkg::IDX_W-1:0];

	always_comb begin
		c_we = 1'b1;
		c_wa = load_idx;
		c_wd = node_y;
		priority if (cmd.c_wr_div) begin
			c_wa = cmd.c_wa;
			c_wd = quot;
		end else if (cmd.c_wr_zero) begin
			c_wa = cmd.c_wa;
			c_wd = '0;
		end else begin
			c_we = cmd.load_start || cmd.load_append;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start || cmd.load_append) x_mem[load_idx] <= node_x;
		if (c_we) c_mem[c_wa] <= c_wd;
		x_a_q <= x_mem[cmd.x_ra];
		x_b_q <= x_mem[cmd.x_rb];
		c_a_q <= c_mem[cmd.c_ra];
		c_b_q <= c_mem[cmd.c_rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ready_q <= 1'b0;
			dup_q   <= 1'b0;
		end else if (cmd.load_start) begin
			count_q <= ndd_pkg::CNT_W'(1);
			ready_q <= 1'b0;
			dup_q   <= 1'b0;
		end else begin
			if (cmd.load_append) count_q <= count_q + 1'b1;
			if (cmd.set_ready) ready_q <= 1'b1;
			if (cmd.set_dup) dup_q <= 1'b1;
		end
	end

	// Exact 33-bit differences for one divided-difference step.
	assign den = {x_a_q[DW-1], x_a_q} - {x_b_q[DW-1], x_b_q};
	assign num = {c_a_q[DW-1], c_a_q} - {c_b_q[DW-1], c_b_q};

	ndd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quot   (quot)
	);

	// One shared multiplier: first the running product, then the coefficient term.
	assign d = ndd_pkg::sat_w({q_q[DW-1], q_q} - {x_b_q[DW-1], x_b_q});

	always_comb begin
		if (cmd.ev_mul_d) begin
			mul_a   = ndd_pkg::mag_d(prod_q);
			mul_b   = ndd_pkg::mag_d(d);
			mul_neg = prod_q[DW-1] ^ d[DW-1];
		end else begin
			mul_a   = ndd_pkg::mag_d(c_a_q);
			mul_b   = ndd_pkg::mag_d(prod_q);
			mul_neg = c_a_q[DW-1] ^ prod_q[DW-1];
		end
	end

	assign p_sat    = ndd_pkg::signed_sat(p_q >> ndd_pkg::FRAC_BITS, p_neg_q);
	assign acc_next = ndd_pkg::sat_w({acc_q[DW-1], acc_q} + {p_sat[DW-1], p_sat});

	always_ff @(posedge clk) begin
		if (cmd.query_load) q_q <= query_point;
		if (cmd.ev_mul_d || cmd.ev_mul_c) begin
			p_q     <= ndd_pkg::WIDE_W'(mul_a) * ndd_pkg::WIDE_W'(mul_b);
			p_neg_q <= mul_neg;
		end
		if (cmd.ev_init) begin
			prod_q <= ndd_pkg::VAL_ONE;
			acc_q  <= c_a_q;
		end else begin
			if (cmd.ev_prod) prod_q <= p_sat;
			if (cmd.ev_acc) acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_set) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_set) begin
			res_status_q <= cmd.out_status;
			unique case (cmd.out_sel)
				ndd_pkg::OUT_COEF: res_value_q <= c_a_q;
				ndd_pkg::OUT_ACC:  res_value_q <= acc_next;
				default:           res_value_q <= '0;
			endcase
		end
	end

	assign sts.count      = count_q;
	assign sts.coef_ready = ready_q;
	assign sts.dup        = dup_q;
	assign sts.den_zero   = den == '0;
	assign sts.div_done   = div_done;
	assign sts.out_free   = !res_valid_q || res_ready;

	assign res_valid  = res_valid_q;
	assign res_value  = res_value_q;
	assign res_status = res_status_q;
endmodule

// ===== hw/rtl/newton_divided_difference_interp.sv =====
// Top level of the Newton divided-difference interpolator.
// Channel items carries one word per request: mode 0 starts a node set with
// (node_x, node_y), mode 1 appends a node, mode 2 evaluates at query_point.
// Channel results returns exactly one word (value, status) per item word.
// A load word is answered in the cycle after acceptance.
// The first evaluation after loading n nodes builds the coefficient table in
// place: n(n-1)/2 entries, each a division on the bit-serial divider unless
// its denominator is zero; the divider makes one quotient bit per cycle.
// Evaluation then steps through the nodes after the first; the single shared
// multiplier is used twice per such node.
// One word is in work at a time; items is ready again once the block is idle
// and the result register is empty or being read.
// A stalled receiver holds the result word in the output register and keeps
// items not ready until the word is taken.
// Reset clears the node count and the flags; the node stores keep their data.
module newton_divided_difference_interp (
	input  logic          clk,
	input  logic          arst_n,
	ndd_item_if.sink      items,
	ndd_result_if.source  results
);
	ndd_pkg::cmd_t cmd;
	ndd_pkg::sts_t sts;

	ndd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.mode     (items.mode),
		.sts      (sts),
		.in_ready (items.ready),
		.cmd      (cmd)
	);

	ndd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.node_x      (items.node_x),
		.node_y      (items.node_y),
		.query_point (items.query_point),
		.res_ready   (results.ready),
		.sts         (sts),
		.res_valid   (results.valid),
		.res_value   (results.value),
		.res_status  (results.status)
	);
endmodule

// ===== hw/rtl/ndd_checker.sv =====
// Port-level checks of the interpolator and their binding to the top level.
`include "newton_divided_difference_interp_defines.svh"

module ndd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        items_valid,
	input logic        items_ready,
	input logic [1:0]  items_mode,
	input logic        results_valid,
	input logic        results_ready,
	input logic [31:0] results_value,
	input logic [1:0]  results_status
);
	// A waiting result word must not change.
	`NDD_ASSERT_NEXT(a_res_hold, results_valid && !results_ready, results_valid && $stable(results_value) && $stable(results_status))
	// Error answers carry a zero value.
	`NDD_ASSERT_SAME(a_err_zero, results_valid && results_status != ndd_pkg::ST_OK, results_value == 32'd0)
	// A word is only taken when the result register can hold its answer.
	`NDD_ASSERT_SAME(a_slot_free, items_valid && items_ready, !results_valid || results_ready)
	// Load and unused-mode words are answered in the next cycle.
	`NDD_ASSERT_NEXT(a_load_answer, items_valid && items_ready && items_mode != ndd_pkg::MODE_EVAL, results_valid)
endmodule

bind newton_divided_difference_interp ndd_checker u_ndd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.items_valid    (items.valid),
	.items_ready    (items.ready),
	.items_mode     (items.mode),
	.results_valid  (results.valid),
	.results_ready  (results.ready),
	.results_value  (results.value),
	.results_status (results.status)
);
